[rtl/clfg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clfg_pkg
// Shared types and constants for the capture line/frame gate.
// ----------------------------------------------------------------------------
package clfg_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KIND_W          = 2;
  localparam int ACTION_W        = 3;
  localparam int SLOT_W          = 6;
  localparam int SLOT_SPAN       = 2 ** SLOT_W;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int IN_DATA_W       = 72;
  localparam int OUT_DATA_W      = 248;

  localparam logic [15:0] EXPECTED_RESET = 16'd64;
  localparam logic [15:0] NO_FRAME       = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINE    = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE     = 3'd0,
    ACT_DISCARD  = 3'd1,
    ACT_ACTIVATE = 3'd2,
    ACT_TRIGGER  = 3'd3,
    ACT_SKIP     = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED = 2'd0,
    REG_CAPTURE  = 2'd1,
    REG_DISCARD  = 2'd2,
    REG_ENDLESS  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT
  } state_t;

  typedef struct packed {
    logic        cap;
    logic        exec;
    logic        rd_issue;
    logic        rd_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_t       kind;
  } dp_sts_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [SLOT_W-1:0] read_slot;
    logic [31:0]       frames_done;
    logic [31:0]       timestamp;
  } in_rec_t;

  typedef struct packed {
    logic [31:0] end_time;
    logic [31:0] last_time;
    logic [31:0] first_time;
    logic [15:0] observed;
    logic [15:0] expected;
    logic [31:0] frame;
  } tbl_rec_t;

  typedef struct packed {
    logic              pad;
    logic [31:0]       skip_count;
    logic [31:0]       trigger_count;
    logic [15:0]       first_sent_frame;
    logic [31:0]       frame_end_time;
    logic [31:0]       last_line_time;
    logic [31:0]       first_line_time;
    logic [15:0]       observed_count;
    logic [15:0]       expected_count;
    logic              record_valid;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       frame_index;
  } out_rec_t;

endpackage
`default_nettype wire

[rtl/clfg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clfg_ctrl
// Request sequencing: input capture, execute, table read wait, output valid.
// ----------------------------------------------------------------------------
module clfg_ctrl
  import clfg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = (sts.kind == KIND_READ) ? ST_RDWAIT : ST_IDLE;
      end
      ST_RDWAIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec     = out_free && (sts.kind != KIND_READ);
        cmd.rd_issue = out_free && (sts.kind == KIND_READ);
      end
      ST_RDWAIT: cmd.rd_load = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec || cmd.rd_load) out_valid_nxt = 1'b1;
    else if (out_tready)          out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

[rtl/clfg_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clfg_dp
// Gate counters, config registers, record table and result register.
// ----------------------------------------------------------------------------
module clfg_dp
  import clfg_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [KIND_W-1:0]     in_tuser,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [ACTION_W-1:0]        out_tuser
);

  // only slots reachable by a read are stored
  localparam int          RD      = (TABLE_DEPTH < SLOT_SPAN) ? TABLE_DEPTH : SLOT_SPAN;
  localparam int          AW      = $clog2(RD);
  localparam int          IW      = $clog2(TABLE_DEPTH);
  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);
  localparam logic [31:0] RD_W    = 32'(RD);
  localparam logic [IW-1:0] RING_LAST = IW'(TABLE_DEPTH - 1);

  logic [15:0] expected_r, capture_r, discard_r;
  logic        endless_r;

  kind_t       kind_r;
  in_rec_t     in_r;

  logic [31:0] fc_r, fc_nxt;
  logic [15:0] lines_r, lines_nxt;
  logic [31:0] ftime_r, ftime_nxt;
  logic [31:0] ltime_r, ltime_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] trig_r, trig_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [15:0] fsent_r, fsent_nxt;
  logic [IW-1:0] ring_r, ring_nxt;
  logic [RD-1:0] valid_r;

  tbl_rec_t    mem [RD];
  tbl_rec_t    mem_q;
  logic        hit_r;

  out_rec_t    res, out_r;
  action_t     act, act_r;

  logic [31:0] slot32, cap_clip;
  logic        wr_ok, tbl_wr, clr_tbl;
  logic [AW-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= EXPECTED_RESET;
      capture_r  <= '0;
      discard_r  <= '0;
      endless_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EXPECTED: expected_r <= cfg_data;
        REG_CAPTURE:  capture_r  <= cfg_data;
        REG_DISCARD:  discard_r  <= cfg_data;
        REG_ENDLESS:  endless_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_r <= kind_t'(in_tuser);
      in_r   <= in_rec_t'(in_tdata);
    end
  end

  assign sts.kind = kind_r;

  always_comb begin
    slot32   = endless_r ? 32'(ring_r) : fc_r;
    cap_clip = ({16'd0, capture_r} > DEPTH_W) ? DEPTH_W : {16'd0, capture_r};
    wr_ok    = endless_r || (fc_r < cap_clip);
    wr_addr  = slot32[AW-1:0];
  end

  always_comb begin
    fc_nxt    = fc_r;
    lines_nxt = lines_r;
    ftime_nxt = ftime_r;
    ltime_nxt = ltime_r;
    pend_nxt  = pend_r;
    trig_nxt  = trig_r;
    skip_nxt  = skip_r;
    fsent_nxt = fsent_r;
    ring_nxt  = ring_r;
    act       = ACT_NONE;
    tbl_wr    = 1'b0;
    clr_tbl   = 1'b0;
    res       = '0;

    if (cmd.rd_load) begin
      res.slot             = in_r.read_slot;
      res.record_valid     = hit_r;
      res.first_sent_frame = fsent_r;
      res.trigger_count    = trig_r;
      res.skip_count       = skip_r;
      if (hit_r) begin
        res.frame_index     = mem_q.frame;
        res.expected_count  = mem_q.expected;
        res.observed_count  = mem_q.observed;
        res.first_line_time = mem_q.first_time;
        res.last_line_time  = mem_q.last_time;
        res.frame_end_time  = mem_q.end_time;
      end
    end else begin
      unique case (kind_r)
        KIND_LINE: begin
          if (fc_r < {16'd0, discard_r}) begin
            act = ACT_DISCARD;
          end else if (pend_r) begin
            act      = ACT_ACTIVATE;
            pend_nxt = 1'b0;
            trig_nxt = trig_r + 32'd1;
            if (fsent_r == NO_FRAME) fsent_nxt = fc_r[15:0];
          end else if (trig_r > (in_r.frames_done + 32'd1)) begin
            act      = ACT_SKIP;
            skip_nxt = skip_r + 32'd1;
          end else begin
            act      = ACT_TRIGGER;
            trig_nxt = trig_r + 32'd1;
          end
          if (lines_r == 16'd0) ftime_nxt = in_r.timestamp;
          ltime_nxt = in_r.timestamp;
          lines_nxt = lines_r + 16'd1;
          res.frame_index     = fc_r;
          res.expected_count  = expected_r;
          res.observed_count  = lines_nxt;
          res.first_line_time = ftime_nxt;
          res.last_line_time  = ltime_nxt;
        end
        KIND_FRAME: begin
          tbl_wr              = wr_ok && (slot32 < RD_W);
          res.frame_index     = fc_r;
          res.expected_count  = expected_r;
          res.observed_count  = lines_r;
          res.first_line_time = ftime_r;
          res.last_line_time  = ltime_r;
          res.frame_end_time  = in_r.timestamp;
          res.record_valid    = wr_ok;
          res.slot            = wr_ok ? slot32[SLOT_W-1:0] : '0;
          fc_nxt    = fc_r + 32'd1;
          ring_nxt  = (ring_r == RING_LAST) ? '0 : ring_r + IW'(1);
          lines_nxt = '0;
          ftime_nxt = '0;
          ltime_nxt = '0;
        end
        KIND_RESTART: begin
          clr_tbl   = 1'b1;
          fc_nxt    = '0;
          lines_nxt = '0;
          ftime_nxt = '0;
          ltime_nxt = '0;
          pend_nxt  = 1'b1;
          trig_nxt  = '0;
          skip_nxt  = '0;
          fsent_nxt = NO_FRAME;
          ring_nxt  = '0;
        end
        KIND_READ: ;
        default: ;
      endcase
      res.first_sent_frame = fsent_nxt;
      res.trigger_count    = trig_nxt;
      res.skip_count       = skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r    <= '0;
      lines_r <= '0;
      ftime_r <= '0;
      ltime_r <= '0;
      pend_r  <= 1'b1;
      trig_r  <= '0;
      skip_r  <= '0;
      fsent_r <= NO_FRAME;
      ring_r  <= '0;
      valid_r <= '0;
    end else if (cmd.exec) begin
      fc_r    <= fc_nxt;
      lines_r <= lines_nxt;
      ftime_r <= ftime_nxt;
      ltime_r <= ltime_nxt;
      pend_r  <= pend_nxt;
      trig_r  <= trig_nxt;
      skip_r  <= skip_nxt;
      fsent_r <= fsent_nxt;
      ring_r  <= ring_nxt;
      if (clr_tbl)     valid_r          <= '0;
      else if (tbl_wr) valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && tbl_wr) begin
      mem[wr_addr] <= '{end_time:   in_r.timestamp,
                        last_time:  ltime_r,
                        first_time: ftime_r,
                        observed:   lines_r,
                        expected:   expected_r,
                        frame:      fc_r};
    end
    if (cmd.rd_issue) begin
      mem_q <= mem[in_r.read_slot[AW-1:0]];
      hit_r <= ({26'd0, in_r.read_slot} < RD_W) && valid_r[in_r.read_slot[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.rd_load) begin
      out_r <= res;
      act_r <= act;
    end
  end

  assign out_tdata = out_r;
  assign out_tuser = act_r;

endmodule
`default_nettype wire

[rtl/capture_line_frame_gate.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capture_line_frame_gate
// Line/frame gating with per-frame record table for a capture stream.
// ----------------------------------------------------------------------------
// Line, frame and restart requests pass the input register, then the output
// register; record reads add a registered table read between the two.
// One request at a time, executed once the output register is free; the next
// request is taken while the previous result waits in the output register.
// Reset (rst_n, synchronous): config to defaults, counters and table
// valid bits cleared at once; no clearing pass.
module capture_line_frame_gate
  import clfg_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // timestamp[31:0], frames_done[63:32], read_slot[69:64], zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  wire logic [KIND_W-1:0]     in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // frame_index, slot, record_valid, expected_count, observed_count,
  // first_line_time, last_line_time, frame_end_time, first_sent_frame,
  // trigger_count, skip_count, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // action[2:0]
  output logic [ACTION_W-1:0]        out_tuser
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  clfg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  clfg_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

[tb/sv/capture_line_frame_gate_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_line_frame_gate_tb
// Self-checking bench for the capture line/frame gate. A local model of the
// gating decisions, line counters and record table predicts every result.
// Directed requests cover the corner cases, then constrained-by-hand random
// frame sequences run under four idle/stall mixes. A scoreboard compares
// each result field by field, in order.
// ----------------------------------------------------------------------------
module capture_line_frame_gate_tb;
  import clfg_pkg::*;

  localparam int DEPTH         = TABLE_DEPTH_DEF;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    action_t  act;
    out_rec_t rec;
  } gate_result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [KIND_W-1:0]     in_tuser  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [ACTION_W-1:0]   out_tuser;

  // register shadows
  logic [15:0] reg_expected;
  logic [15:0] reg_capture;
  logic [15:0] reg_discard;
  logic        reg_endless;

  // gate state
  logic [31:0] frame_no;
  logic [15:0] line_cnt;
  logic [31:0] first_ts;
  logic [31:0] last_ts;
  logic        arm_pending;
  logic [31:0] trig_total;
  logic [31:0] skip_total;
  logic [15:0] first_armed;
  bit          tbl_valid[DEPTH];
  bit          tbl_written[DEPTH];
  tbl_rec_t    tbl[DEPTH];

  gate_result_t pending_results[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int requests_sent = 0;

  always #6 clk = ~clk;

  capture_line_frame_gate uut (.*);

  function automatic void clear_session();
    frame_no    = '0;
    line_cnt    = '0;
    first_ts    = '0;
    last_ts     = '0;
    arm_pending = 1'b1;
    trig_total  = '0;
    skip_total  = '0;
    first_armed = NO_FRAME;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
  endfunction

  function automatic gate_result_t gate_predict(kind_t kind, logic [31:0] ts,
                                                logic [31:0] done,
                                                logic [SLOT_W-1:0] rslot);
    gate_result_t r;
    int           cap;
    bit           wr;
    logic [5:0]   wslot;
    r.act = ACT_NONE;
    r.rec = '0;
    case (kind)
      KIND_LINE: begin
        if (frame_no < {16'd0, reg_discard}) begin
          r.act = ACT_DISCARD;
        end else if (arm_pending) begin
          r.act       = ACT_ACTIVATE;
          arm_pending = 1'b0;
          trig_total++;
          if (first_armed == NO_FRAME) first_armed = frame_no[15:0];
        end else if (trig_total > done + 32'd1) begin
          r.act = ACT_SKIP;
          skip_total++;
        end else begin
          r.act = ACT_TRIGGER;
          trig_total++;
        end
        if (line_cnt == 16'd0) first_ts = ts;
        last_ts  = ts;
        line_cnt = line_cnt + 16'd1;
        r.rec.frame_index     = frame_no;
        r.rec.expected_count  = reg_expected;
        r.rec.observed_count  = line_cnt;
        r.rec.first_line_time = first_ts;
        r.rec.last_line_time  = last_ts;
      end
      KIND_FRAME: begin
        cap   = (reg_capture > DEPTH) ? DEPTH : int'(reg_capture);
        wr    = reg_endless || (frame_no < cap);
        wslot = frame_no[5:0];
        r.rec.frame_index     = frame_no;
        r.rec.expected_count  = reg_expected;
        r.rec.observed_count  = line_cnt;
        r.rec.first_line_time = first_ts;
        r.rec.last_line_time  = last_ts;
        r.rec.frame_end_time  = ts;
        if (wr) begin
          tbl_valid[wslot]      = 1'b1;
          tbl_written[wslot]    = 1'b1;
          tbl[wslot].frame      = frame_no;
          tbl[wslot].expected   = reg_expected;
          tbl[wslot].observed   = line_cnt;
          tbl[wslot].first_time = first_ts;
          tbl[wslot].last_time  = last_ts;
          tbl[wslot].end_time   = ts;
          r.rec.slot         = wslot;
          r.rec.record_valid = 1'b1;
        end
        frame_no = frame_no + 32'd1;
        line_cnt = '0;
        first_ts = '0;
        last_ts  = '0;
      end
      KIND_RESTART: clear_session();
      default: begin
        r.rec.slot = rslot;
        if (tbl_valid[rslot]) begin
          r.rec.record_valid    = 1'b1;
          r.rec.frame_index     = tbl[rslot].frame;
          r.rec.expected_count  = tbl[rslot].expected;
          r.rec.observed_count  = tbl[rslot].observed;
          r.rec.first_line_time = tbl[rslot].first_time;
          r.rec.last_line_time  = tbl[rslot].last_time;
          r.rec.frame_end_time  = tbl[rslot].end_time;
        end
      end
    endcase
    r.rec.first_sent_frame = first_armed;
    r.rec.trigger_count    = trig_total;
    r.rec.skip_count       = skip_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen  <= hold_seq;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    gate_result_t want;
    out_rec_t     got;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request pending, action 0x%0h", out_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        got  = out_tdata;
        check_field("action", 32'(want.act), 32'(out_tuser));
        check_field("frame_index", want.rec.frame_index, got.frame_index);
        check_field("slot", 32'(want.rec.slot), 32'(got.slot));
        check_field("record_valid", 32'(want.rec.record_valid), 32'(got.record_valid));
        check_field("expected_count", 32'(want.rec.expected_count),
                    32'(got.expected_count));
        check_field("observed_count", 32'(want.rec.observed_count),
                    32'(got.observed_count));
        check_field("first_line_time", want.rec.first_line_time, got.first_line_time);
        check_field("last_line_time", want.rec.last_line_time, got.last_line_time);
        check_field("frame_end_time", want.rec.frame_end_time, got.frame_end_time);
        check_field("first_sent_frame", 32'(want.rec.first_sent_frame),
                    32'(got.first_sent_frame));
        check_field("trigger_count", want.rec.trigger_count, got.trigger_count);
        check_field("skip_count", want.rec.skip_count, got.skip_count);
      end
    end
  end

  // valid stays high after the handshake; whoever consumes time next lowers it
  task automatic send_req(kind_t kind, logic [31:0] ts, logic [31:0] done,
                          logic [SLOT_W-1:0] rslot);
    in_rec_t payload;
    payload             = '0;
    payload.timestamp   = ts;
    payload.frames_done = done;
    payload.read_slot   = rslot;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= payload;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(gate_predict(kind, ts, done, rslot));
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_EXPECTED: reg_expected = value;
      REG_CAPTURE:  reg_capture  = value;
      REG_DISCARD:  reg_discard  = value;
      default:      reg_endless  = value[0];
    endcase
  endtask

  task automatic set_config(logic [15:0] expected, logic [15:0] capture,
                            logic [15:0] discard, logic endless);
    wait_drained();
    write_reg(REG_EXPECTED, expected);
    write_reg(REG_CAPTURE, capture);
    write_reg(REG_DISCARD, discard);
    write_reg(REG_ENDLESS, {15'($urandom), endless});
    cfg_valid <= 1'b0;
  endtask

  // mostly near the trigger count so both trigger and busy skip show up
  function automatic logic [31:0] pick_done();
    if ($urandom_range(9) == 0) return $urandom;
    return trig_total - $urandom_range(3);
  endfunction

  function automatic int pick_written_slot();
    int picks[$];
    foreach (tbl_written[i]) if (tbl_written[i]) picks.push_back(i);
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(picks.size() - 1)];
  endfunction

  task automatic send_frame_seq(int lines);
    repeat (lines) send_req(KIND_LINE, $urandom, pick_done(), 6'($urandom));
    send_req(KIND_FRAME, $urandom, $urandom, 6'($urandom));
  endtask

  task automatic test_gating_defaults();
    send_req(KIND_LINE, 32'h0, 32'h0, 6'h3F);           // activate
    send_req(KIND_LINE, 32'hFFFF_FFFF, 32'h0, 6'h0);    // trigger
    send_req(KIND_LINE, 32'h1234_5678, 32'h0, 6'h15);   // busy skip
    send_req(KIND_LINE, 32'h8000_0000, 32'hFFFF_FFFF, 6'h2A); // done+1 wraps
    send_req(KIND_LINE, 32'h0000_0001, 32'hFFFF_FFFE, 6'h0);
    send_req(KIND_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F); // capture 0: no write
    send_req(KIND_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
  endtask

  task automatic test_discard_linear();
    set_config(16'hFFFF, 16'd2, 16'd1, 1'b0);
    send_req(KIND_RESTART, 32'h0, 32'h0, 6'h0);
    send_req(KIND_LINE, 32'h10, 32'h0, 6'h0);           // discarded
    send_req(KIND_FRAME, 32'h20, 32'h0, 6'h0);          // slot 0
    send_req(KIND_LINE, 32'h30, 32'h0, 6'h0);           // activate in frame 1
    send_req(KIND_FRAME, 32'h40, 32'h0, 6'h0);          // slot 1
    send_req(KIND_FRAME, 32'h50, 32'h0, 6'h0);          // table full
    send_req(KIND_READ, 32'h0, 32'h0, 6'd0);
    send_req(KIND_READ, 32'h0, 32'h0, 6'd1);
    send_req(KIND_RESTART, 32'h0, 32'h0, 6'h0);
    send_req(KIND_READ, 32'h0, 32'h0, 6'd1);            // cleared by restart
  endtask

  task automatic test_discard_all();
    set_config(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    send_req(KIND_RESTART, 32'h0, 32'h0, 6'h0);
    send_req(KIND_LINE, 32'hFFFF_FFFF, 32'h0, 6'h0);
    send_req(KIND_FRAME, 32'h0, 32'h0, 6'h0);
    send_req(KIND_LINE, 32'h5555_AAAA, 32'h0, 6'h0);
  endtask

  task automatic test_ring();
    set_config(16'd7, 16'd0, 16'd0, 1'b1);
    send_req(KIND_RESTART, 32'h0, 32'h0, 6'h0);
    send_req(KIND_FRAME, 32'h100, 32'h0, 6'h0);
    send_req(KIND_LINE, 32'h200, 32'h0, 6'h0);
    send_req(KIND_FRAME, 32'h300, 32'h0, 6'h0);
    send_req(KIND_READ, 32'h0, 32'h0, 6'd1);
  endtask

  task automatic test_long_frame();
    set_config(16'd100, 16'd64, 16'd0, 1'b0);
    send_req(KIND_RESTART, 32'h0, 32'h0, 6'h0);
    for (int i = 0; i < 60; i++) send_req(KIND_LINE, 32'(i), trig_total, 6'($urandom));
    send_req(KIND_FRAME, 32'hABCD_0000, 32'h0, 6'h0);
    send_req(KIND_READ, 32'h0, 32'h0, 6'd0);
  endtask

  task automatic test_backpressure();
    set_config(16'($urandom), 16'd64, 16'd0, 1'b1);
    send_req(KIND_RESTART, 32'h0, 32'h0, 6'h0);
    hold_seq <= hold_seq + 1;
    repeat (8) send_frame_seq($urandom_range(4));
    wait_drained();
    send_frame_seq(2);
  endtask

  task automatic run_random(int n_req, int idle_pct, int stall_prob);
    int choice;
    int slot;
    int stop_at;
    send_idle_pct = idle_pct;
    stall_pct     = stall_prob;
    stop_at       = requests_sent + n_req;
    send_req(KIND_RESTART, $urandom, $urandom, 6'($urandom));
    while (requests_sent < stop_at) begin
      choice = $urandom_range(99);
      if (choice < 3) begin
        send_req(KIND_RESTART, $urandom, $urandom, 6'($urandom));
      end else if (choice < 15) begin
        slot = pick_written_slot();
        if (slot >= 0) send_req(KIND_READ, $urandom, $urandom, 6'(slot));
      end else begin
        send_frame_seq($urandom_range(6));
      end
    end
  endtask

  initial begin
    reg_expected = EXPECTED_RESET;
    reg_capture  = '0;
    reg_discard  = '0;
    reg_endless  = 1'b0;
    clear_session();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_gating_defaults();
    test_discard_linear();
    test_discard_all();
    test_ring();
    test_long_frame();
    test_backpressure();

    set_config(16'($urandom), 16'hFFFF, 16'd0, 1'b0);
    run_random(190, 0, 0);
    set_config(16'($urandom), 16'd0, 16'd3, 1'b1);
    run_random(190, 77, 0);
    set_config(16'hFFFF, 16'd5, 16'd0, 1'b0);
    run_random(190, 0, 77);
    set_config(16'd0, 16'd40, 16'd1, 1'b1);
    run_random(190, 31, 31);

    wait_drained();
    $display("covered gating corners, long frames, linear and ring tables, long hold-off");
    $display("%0d requests sent, %0d results checked, %0d mismatches",
             requests_sent, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("capture_line_frame_gate_tb: done, clean");
    end else begin
      $display("capture_line_frame_gate_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("capture_line_frame_gate_tb: done, errors");
    $finish;
  end

endmodule
